@@ rtl/v4au_pkg.sv @@
// Shared types, opcodes, widths and helper functions of the vector ALU.
package v4au_pkg;

  localparam logic [3:0] OP_NEG   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_SCALE = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_CMP   = 4'd5;
  localparam logic [3:0] OP_DOT   = 4'd6;
  localparam logic [3:0] OP_PROJ  = 4'd7;
  localparam logic [3:0] OP_REJ   = 4'd8;
  localparam logic [3:0] OP_MAG   = 4'd9;

  localparam int NUM_W   = 96;
  localparam int DEN_W   = 65;
  localparam int DIV_QW  = 33;
  localparam int DIV_LAT = DIV_QW + 2;
  localparam int SQ_W    = 32;
  localparam int SQ_LAT  = SQ_W + 2;
  localparam int SAT_W   = 37;

  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic signed [31:0] scalar_out;
    logic               is_equal;
    logic               error;
  } out_t;

  typedef logic [3:0][31:0] vec_t;

  function automatic vec_t get_a(input in_t t);
    vec_t v;
    v[0] = t.a_x;
    v[1] = t.a_y;
    v[2] = t.a_z;
    v[3] = t.a_w;
    return v;
  endfunction

  function automatic vec_t get_b(input in_t t);
    vec_t v;
    v[0] = t.b_x;
    v[1] = t.b_y;
    v[2] = t.b_z;
    v[3] = t.b_w;
    return v;
  endfunction

  function automatic logic [SAT_W-1:0] sext_w(input logic [31:0] v);
    return {{(SAT_W-32){v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat_word(input logic [SAT_W-1:0] v);
    logic [31:0] r;
    if (!v[SAT_W-1] && (v[SAT_W-2:31] != '0)) begin
      r = WORD_MAX;
    end else if (v[SAT_W-1] && (v[SAT_W-2:31] != '1)) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/v4au_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, rounded and clamped.
module v4au_div (
  input  logic                         clk,
  input  logic [v4au_pkg::NUM_W-1:0]   num_i,
  input  logic [v4au_pkg::DEN_W-1:0]   den_i,
  output logic [v4au_pkg::DIV_QW:0]    quo_o
);
  import v4au_pkg::*;

  localparam int W = DEN_W + DIV_QW + 1;

  logic [NUM_W-1:0]  rem_r [DIV_QW+1];
  logic [DIV_QW-1:0] quo_r [DIV_QW+1];
  logic [DEN_W-1:0]  den_r [DIV_QW+1];
  logic              ovf_r [DIV_QW+1];
  logic [DIV_QW:0]   quo_out_r;
  logic              ovf_nxt;
  logic              rnd_up;

  assign ovf_nxt = W'(num_i) >= (W'(den_i) << DIV_QW);

  always_ff @(posedge clk) begin
    rem_r[0] <= num_i;
    quo_r[0] <= '0;
    den_r[0] <= den_i;
    ovf_r[0] <= ovf_nxt;
  end

  genvar s;
  generate
    for (s = 0; s < DIV_QW; s++) begin : g_step
      localparam int K = DIV_QW - 1 - s;
      logic [W-1:0] dsh;
      logic [W-1:0] rw;
      logic [W-1:0] diff;
      logic         ge;

      assign dsh  = W'(den_r[s]) << K;
      assign rw   = W'(rem_r[s]);
      assign ge   = rw >= dsh;
      assign diff = rw - dsh;

      always_ff @(posedge clk) begin
        rem_r[s+1] <= ge ? diff[NUM_W-1:0] : rem_r[s];
        quo_r[s+1] <= quo_r[s] | ({{(DIV_QW-1){1'b0}}, ge} << K);
        den_r[s+1] <= den_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  endgenerate

  assign rnd_up = W'({rem_r[DIV_QW], 1'b0}) >= W'(den_r[DIV_QW]);

  always_ff @(posedge clk) begin
    quo_out_r <= ovf_r[DIV_QW] ? {1'b1, {DIV_QW{1'b0}}}
                               : {1'b0, quo_r[DIV_QW]} + (DIV_QW+1)'(rnd_up);
  end

  assign quo_o = quo_out_r;

endmodule

@@ rtl/v4au_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, rounded to nearest.
module v4au_sqrt (
  input  logic                       clk,
  input  logic [2*v4au_pkg::SQ_W-1:0] x_i,
  output logic [v4au_pkg::SQ_W:0]    root_o
);
  import v4au_pkg::*;

  logic [SQ_W+3:0]   rem_r  [SQ_W+1];
  logic [SQ_W-1:0]   root_r [SQ_W+1];
  logic [2*SQ_W-1:0] x_r    [SQ_W];
  logic [SQ_W:0]     root_out_r;

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    x_r[0]    <= x_i;
  end

  genvar s;
  generate
    for (s = 0; s < SQ_W; s++) begin : g_step
      localparam int I = SQ_W - 1 - s;
      logic [SQ_W+3:0] remsh;
      logic [SQ_W+3:0] trial;
      logic            ge;

      assign remsh = {rem_r[s][SQ_W+1:0], x_r[s][2*I+1 -: 2]};
      assign trial = {2'b00, root_r[s], 2'b01};
      assign ge    = remsh >= trial;

      always_ff @(posedge clk) begin
        rem_r[s+1]  <= ge ? remsh - trial : remsh;
        root_r[s+1] <= {root_r[s][SQ_W-2:0], ge};
      end

      if (s < SQ_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          x_r[s+1] <= x_r[s];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    root_out_r <= {1'b0, root_r[SQ_W]}
                + (SQ_W+1)'(rem_r[SQ_W] > {4'b0000, root_r[SQ_W]});
  end

  assign root_o = root_out_r;

endmodule

@@ rtl/vec4_arithmetic_unit.sv @@
// Top level of the four-component Q16.16 vector ALU.
//
// Usage: drive in_data and raise start; busy is always low, so every cycle
// with start high transfers one item (op, vectors a and b, scalar_in).
// Each item yields one result on out_data, marked by a one-cycle out_valid
// strobe; the receiver must take it in that cycle.
// Throughput: one item per clock cycle, back to back.
// The delay from the start transfer to the result transfer is the same
// for every opcode. It is set by the 33-stage restoring divider
// (one quotient bit per stage, plus overflow check and rounding) that
// serves scale, divide, dot, project and reject, after seven front stages
// of registers, multipliers, adder tree and partial-product combine.
// Magnitude runs through a 32-stage root pipeline aligned to the divider.
// Reset clears all valid bits; items in flight are dropped and no strobe
// follows. Results saturate; a zero divisor gives zero fields with error.
module vec4_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  v4au_pkg::in_t   in_data,
  output logic            out_valid,
  output v4au_pkg::out_t  out_data
);
  import v4au_pkg::*;

  localparam int SIDE_LAST = DIV_LAT - 1;
  localparam int LATENCY   = DIV_LAT + 8;

  typedef struct packed {
    vec_t        abs_a;
    vec_t        abs_b;
    logic [31:0] abs_s;
    logic        eq;
    logic        szero;
  } mid_t;

  typedef struct packed {
    logic [64:0] abs_ab;
    logic        ab_neg;
    logic [64:0] bb;
    logic        bb_zero;
    logic        aa_hi;
    logic [63:0] aa_lo;
  } dot_t;

  typedef struct packed {
    logic [3:0] op;
    vec_t       a;
    vec_t       res;
    logic [3:0] neg;
    logic       eq;
    logic       err;
    logic       aa_hi;
  } side_t;

  in_t              in_q_r [1:7];
  logic             vld_r  [1:7];
  logic [63:0]      pab_r  [4];
  logic [63:0]      pbb_r  [4];
  logic [63:0]      paa_r  [4];
  mid_t             mid_r  [2:7];
  logic [64:0]      ab_p_r [2];
  logic [64:0]      bb_p_r [2];
  logic [64:0]      aa_p_r [2];
  logic [3:0][63:0] psc_r  [3:7];
  logic [65:0]      ab_s_r;
  logic [65:0]      bb_s_r;
  logic [65:0]      aa_s_r;
  dot_t             dt_r   [5:7];
  logic [3:0][63:0] ppl_r;
  logic [3:0][64:0] pph_r;
  logic [3:0][NUM_W-1:0] npj_r;
  side_t            side_r [DIV_LAT];
  logic             sv_r   [DIV_LAT];
  logic [SQ_W:0]    sq_d_r;
  out_t             out_r;
  logic             out_valid_r;

  vec_t             a1;
  vec_t             b1;
  vec_t             a7;
  vec_t             b7;
  mid_t             mid_nxt;
  dot_t             dt_nxt;
  logic [65:0]      ab_mag;
  logic [NUM_W-1:0] num_nxt [4];
  logic [DEN_W-1:0] den_nxt [4];
  side_t            side_nxt;
  logic [DIV_QW:0]  quo [4];
  logic [SQ_W:0]    sq_q;
  logic [SAT_W-1:0] val [4];
  vec_t             rv;
  logic [31:0]      so;
  out_t             out_nxt;
  side_t            sd;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 7; k++) vld_r[k] <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) sv_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[1] <= start && !busy;
      for (int k = 2; k <= 7; k++) vld_r[k] <= vld_r[k-1];
      sv_r[0] <= vld_r[7];
      for (int k = 1; k < DIV_LAT; k++) sv_r[k] <= sv_r[k-1];
      out_valid_r <= sv_r[SIDE_LAST];
    end
  end

  always_comb begin
    a1 = get_a(in_q_r[1]);
    b1 = get_b(in_q_r[1]);
    mid_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      mid_nxt.abs_a[i] = a1[i][31] ? 32'd0 - a1[i] : a1[i];
      mid_nxt.abs_b[i] = b1[i][31] ? 32'd0 - b1[i] : b1[i];
    end
    mid_nxt.abs_s = in_q_r[1].scalar_in[31] ? 32'd0 - in_q_r[1].scalar_in
                                            : in_q_r[1].scalar_in;
    mid_nxt.eq    = (a1 == b1);
    mid_nxt.szero = (in_q_r[1].scalar_in == '0);
  end

  always_comb begin
    ab_mag         = ab_s_r[65] ? 66'd0 - ab_s_r : ab_s_r;
    dt_nxt.abs_ab  = ab_mag[64:0];
    dt_nxt.ab_neg  = ab_s_r[65];
    dt_nxt.bb      = bb_s_r[64:0];
    dt_nxt.bb_zero = (bb_s_r == '0);
    dt_nxt.aa_hi   = (aa_s_r[65:64] != 2'b00);
    dt_nxt.aa_lo   = aa_s_r[63:0];
  end

  always_ff @(posedge clk) begin
    in_q_r[1] <= in_data;
    for (int k = 2; k <= 7; k++) in_q_r[k] <= in_q_r[k-1];
    for (int i = 0; i < 4; i++) begin
      pab_r[i] <= $signed(a1[i]) * $signed(b1[i]);
      pbb_r[i] <= $signed(b1[i]) * $signed(b1[i]);
      paa_r[i] <= $signed(a1[i]) * $signed(a1[i]);
    end
    mid_r[2] <= mid_nxt;
    for (int k = 3; k <= 7; k++) mid_r[k] <= mid_r[k-1];
    for (int j = 0; j < 2; j++) begin
      ab_p_r[j] <= {pab_r[2*j][63], pab_r[2*j]} + {pab_r[2*j+1][63], pab_r[2*j+1]};
      bb_p_r[j] <= {pbb_r[2*j][63], pbb_r[2*j]} + {pbb_r[2*j+1][63], pbb_r[2*j+1]};
      aa_p_r[j] <= {paa_r[2*j][63], paa_r[2*j]} + {paa_r[2*j+1][63], paa_r[2*j+1]};
    end
    for (int i = 0; i < 4; i++) psc_r[3][i] <= mid_r[2].abs_a[i] * mid_r[2].abs_s;
    for (int k = 4; k <= 7; k++) psc_r[k] <= psc_r[k-1];
    ab_s_r <= {ab_p_r[0][64], ab_p_r[0]} + {ab_p_r[1][64], ab_p_r[1]};
    bb_s_r <= {bb_p_r[0][64], bb_p_r[0]} + {bb_p_r[1][64], bb_p_r[1]};
    aa_s_r <= {aa_p_r[0][64], aa_p_r[0]} + {aa_p_r[1][64], aa_p_r[1]};
    dt_r[5] <= dt_nxt;
    dt_r[6] <= dt_r[5];
    dt_r[7] <= dt_r[6];
    for (int i = 0; i < 4; i++) begin
      ppl_r[i] <= dt_r[5].abs_ab[31:0] * mid_r[5].abs_b[i];
      pph_r[i] <= dt_r[5].abs_ab[64:32] * mid_r[5].abs_b[i];
      npj_r[i] <= NUM_W'(ppl_r[i]) + (NUM_W'(pph_r[i]) << 32);
    end
    side_r[0] <= side_nxt;
    for (int k = 1; k < DIV_LAT; k++) side_r[k] <= side_r[k-1];
    sq_d_r <= sq_q;
    out_r  <= out_nxt;
  end

  always_comb begin
    a7 = get_a(in_q_r[7]);
    b7 = get_b(in_q_r[7]);
    side_nxt       = '0;
    side_nxt.op    = in_q_r[7].op;
    side_nxt.a     = a7;
    side_nxt.eq    = mid_r[7].eq;
    side_nxt.aa_hi = dt_r[7].aa_hi;
    for (int i = 0; i < 4; i++) begin
      num_nxt[i] = '0;
      den_nxt[i] = DEN_W'(1);
    end
    unique case (in_q_r[7].op)
      OP_NEG: begin
        for (int i = 0; i < 4; i++) side_nxt.res[i] = sat_word(SAT_W'(0) - sext_w(a7[i]));
      end
      OP_ADD: begin
        for (int i = 0; i < 4; i++) side_nxt.res[i] = sat_word(sext_w(a7[i]) + sext_w(b7[i]));
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) side_nxt.res[i] = sat_word(sext_w(a7[i]) - sext_w(b7[i]));
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          num_nxt[i]      = NUM_W'(psc_r[7][i]);
          den_nxt[i]      = DEN_W'(1) << FRAC_BITS;
          side_nxt.neg[i] = a7[i][31] ^ in_q_r[7].scalar_in[31];
        end
      end
      OP_DIV: begin
        for (int i = 0; i < 4; i++) begin
          num_nxt[i]      = NUM_W'(mid_r[7].abs_a[i]) << FRAC_BITS;
          den_nxt[i]      = DEN_W'(mid_r[7].abs_s);
          side_nxt.neg[i] = a7[i][31] ^ in_q_r[7].scalar_in[31];
        end
        side_nxt.err = mid_r[7].szero;
      end
      OP_DOT: begin
        num_nxt[0]      = NUM_W'(dt_r[7].abs_ab);
        den_nxt[0]      = DEN_W'(1) << FRAC_BITS;
        side_nxt.neg[0] = dt_r[7].ab_neg;
      end
      OP_PROJ, OP_REJ: begin
        for (int i = 0; i < 4; i++) begin
          num_nxt[i]      = npj_r[i];
          den_nxt[i]      = dt_r[7].bb;
          side_nxt.neg[i] = dt_r[7].ab_neg ^ b7[i][31];
        end
        side_nxt.err = dt_r[7].bb_zero;
      end
      default: begin
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_lane
      v4au_div u_div (
        .clk   (clk),
        .num_i (num_nxt[g]),
        .den_i (den_nxt[g]),
        .quo_o (quo[g])
      );
    end
  endgenerate

  v4au_sqrt u_sqrt (
    .clk    (clk),
    .x_i    (dt_r[7].aa_lo),
    .root_o (sq_q)
  );

  always_comb begin
    sd = side_r[SIDE_LAST];
    for (int i = 0; i < 4; i++) begin
      val[i] = sd.neg[i] ? SAT_W'(0) - SAT_W'(quo[i]) : SAT_W'(quo[i]);
    end
    rv      = '0;
    so      = '0;
    out_nxt = '0;
    if (sd.err) begin
      out_nxt.error = 1'b1;
    end else begin
      unique case (sd.op)
        OP_NEG, OP_ADD, OP_SUB: begin
          rv = sd.res;
        end
        OP_SCALE, OP_DIV, OP_PROJ: begin
          for (int i = 0; i < 4; i++) rv[i] = sat_word(val[i]);
        end
        OP_REJ: begin
          for (int i = 0; i < 4; i++) rv[i] = sat_word(sext_w(sd.a[i]) - val[i]);
        end
        OP_DOT: begin
          so = sat_word(val[0]);
        end
        OP_MAG: begin
          so = sd.aa_hi ? WORD_MAX : sat_word(SAT_W'(sq_d_r));
        end
        OP_CMP: begin
          out_nxt.is_equal = sd.eq;
        end
        default: begin
        end
      endcase
    end
    out_nxt.r_x        = rv[0];
    out_nxt.r_y        = rv[1];
    out_nxt.r_z        = rv[2];
    out_nxt.r_w        = rv[3];
    out_nxt.scalar_out = so;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("transfer did not produce a result strobe at fixed latency");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching input transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (out_data.r_x == '0 && out_data.r_y == '0 &&
      out_data.r_z == '0 && out_data.r_w == '0 && out_data.scalar_out == '0 &&
      !out_data.is_equal))
    else $error("error result carries nonzero fields");

endmodule

@@ bench/v4au_checker.sv @@
// Result checker for the vector ALU: predicts each transfer and compares outputs.
module v4au_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  v4au_pkg::in_t   in_data,
  input  logic            out_valid,
  input  v4au_pkg::out_t  out_data,
  output int              fail_count,
  output int              pending
);
  import v4au_pkg::*;

  localparam int FRAC = 16;

  out_t expected_results[$];

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] abs32(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // round to nearest, ties away from zero, magnitude capped at 2^40
  function automatic logic signed [63:0] round_quot(input bit neg, input logic [191:0] num,
                                                    input logic [191:0] den);
    logic [191:0] q;
    logic signed [63:0] m;
    q = (2 * num + den) / (2 * den);
    m = (q > (192'd1 << 40)) ? (64'sd1 <<< 40) : $signed(q[63:0]);
    return neg ? -m : m;
  endfunction

  function automatic logic signed [71:0] dot4(input vec_t x, input vec_t y);
    logic signed [71:0] acc;
    logic signed [71:0] xs, ys;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      xs = $signed(x[i]);
      ys = $signed(y[i]);
      acc = acc + xs * ys;
    end
    return acc;
  endfunction

  function automatic logic [63:0] root_nearest(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return (x > res) ? res + 1 : res;
  endfunction

  function automatic out_t alu_result(input in_t t);
    out_t o;
    vec_t av, bv;
    logic signed [31:0] r[4];
    logic signed [63:0] ai, bi, p;
    logic signed [71:0] ab, bb, aa;
    logic [191:0] abm;
    bit ng;
    o = '0;
    av = {t.a_w, t.a_z, t.a_y, t.a_x};
    bv = {t.b_w, t.b_z, t.b_y, t.b_x};
    for (int i = 0; i < 4; i++) r[i] = '0;
    case (t.op)
      OP_NEG, OP_ADD, OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          ai = $signed(av[i]);
          bi = $signed(bv[i]);
          r[i] = clip32(t.op == OP_NEG ? -ai : (t.op == OP_ADD ? ai + bi : ai - bi));
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++)
          r[i] = clip32(round_quot(av[i][31] != t.scalar_in[31],
                                   abs32(av[i]) * abs32(t.scalar_in), 192'd1 << FRAC));
      end
      OP_DIV: begin
        if (t.scalar_in == 0) begin
          o.error = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++)
            r[i] = clip32(round_quot(av[i][31] != t.scalar_in[31],
                                     192'(abs32(av[i])) << FRAC, abs32(t.scalar_in)));
        end
      end
      OP_CMP: o.is_equal = (av == bv);
      OP_DOT: begin
        ab = dot4(av, bv);
        ng = ab < 0;
        o.scalar_out = clip32(round_quot(ng, ng ? -ab : ab, 192'd1 << FRAC));
      end
      OP_PROJ, OP_REJ: begin
        bb = dot4(bv, bv);
        ab = dot4(av, bv);
        ng = ab < 0;
        abm = ng ? -ab : ab;
        if (bb == 0) begin
          o.error = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            p = round_quot(ng != bv[i][31], abm * abs32(bv[i]), bb);
            r[i] = (t.op == OP_PROJ) ? clip32(p) : clip32($signed(av[i]) - p);
          end
        end
      end
      OP_MAG: begin
        aa = dot4(av, av);
        o.scalar_out = (aa >= (72'sd1 <<< 64)) ? 32'sh7fffffff
                                               : clip32($signed(root_nearest(aa[63:0])));
      end
      default: ;
    endcase
    o.r_x = r[0];
    o.r_y = r[1];
    o.r_z = r[2];
    o.r_w = r[3];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  initial pending = 0;

  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(alu_result(in_data));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("r_x", e.r_x, out_data.r_x);
          check_field("r_y", e.r_y, out_data.r_y);
          check_field("r_z", e.r_z, out_data.r_z);
          check_field("r_w", e.r_w, out_data.r_w);
          check_field("scalar_out", e.scalar_out, out_data.scalar_out);
          check_field("is_equal", e.is_equal, out_data.is_equal);
          check_field("error", e.error, out_data.error);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the vector ALU regression: clock, reset, stimulus and verdict.
module testbench;
  import v4au_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_TAIL    = 100;
  localparam int CYCLE_LIMIT  = 200000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  in_t   in_data = '0;
  logic  out_valid;
  out_t  out_data;
  int    fail_count, pending;
  int    cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vec4_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  v4au_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vec4_arithmetic_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return ($urandom_range(0, 1) ? 32'h10000 : 32'hffff0000);
      4, 5: return $signed($urandom_range(0, 64)) - 32 <<< 16;
      6: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t vector_item(input logic [3:0] op, input logic [31:0] av,
                                      input logic [31:0] bv, input logic [31:0] s);
    in_t t;
    t.op = op;
    t.a_x = av; t.a_y = av; t.a_z = av; t.a_w = av;
    t.b_x = bv; t.b_y = bv; t.b_z = bv; t.b_w = bv;
    t.scalar_in = s;
    return t;
  endfunction

  function automatic in_t random_item();
    in_t t;
    t.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
    t.a_x = pick_word(); t.a_y = pick_word(); t.a_z = pick_word(); t.a_w = pick_word();
    t.b_x = pick_word(); t.b_y = pick_word(); t.b_z = pick_word(); t.b_w = pick_word();
    t.scalar_in = pick_word();
    case ($urandom_range(0, 9))
      0: {t.b_x, t.b_y, t.b_z, t.b_w} = '0;
      1: {t.b_x, t.b_y, t.b_z, t.b_w} = {t.a_x, t.a_y, t.a_z, t.a_w};
      2: t.scalar_in = '0;
      default: ;
    endcase
    return t;
  endfunction

  task automatic transfer(input in_t t);
    bit taken;
    in_data <= t;
    start <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic maybe_idle(input bit allowed);
    int gap;
    if (allowed && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    in_t directed[$];
    in_t t;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(vector_item(OP_NEG, 32'h80000000, 0, 0));
    directed.push_back(vector_item(OP_NEG, 32'h7fffffff, 0, 0));
    directed.push_back(vector_item(OP_ADD, 32'h7fffffff, 32'h7fffffff, 0));
    directed.push_back(vector_item(OP_ADD, 32'h80000000, 32'h80000000, 0));
    directed.push_back(vector_item(OP_SUB, 32'h80000000, 32'h7fffffff, 0));
    directed.push_back(vector_item(OP_SCALE, 32'h80000000, 0, 32'h80000000));
    directed.push_back(vector_item(OP_SCALE, 32'h00018000, 0, 32'hffff8000));
    directed.push_back(vector_item(OP_DIV, 32'h00030000, 0, 32'h0));
    directed.push_back(vector_item(OP_DIV, 32'h80000000, 0, 32'hffffffff));
    directed.push_back(vector_item(OP_DIV, 32'h00010000, 0, 32'h00030000));
    directed.push_back(vector_item(OP_CMP, 32'h12345678, 32'h12345678, 0));
    t = vector_item(OP_CMP, 32'h12345678, 32'h12345678, 0);
    t.b_w = 32'h12345679;
    directed.push_back(t);
    directed.push_back(vector_item(OP_DOT, 32'h7fffffff, 32'h7fffffff, 0));
    directed.push_back(vector_item(OP_DOT, 32'h80000000, 32'h7fffffff, 0));
    directed.push_back(vector_item(OP_PROJ, 32'h00020000, 32'h0, 0));
    directed.push_back(vector_item(OP_PROJ, 32'h80000000, 32'h00000001, 0));
    directed.push_back(vector_item(OP_REJ, 32'h00020000, 32'h0, 0));
    t = vector_item(OP_REJ, 32'h00030000, 32'h00010000, 0);
    t.b_y = 32'h0;
    directed.push_back(t);
    directed.push_back(vector_item(OP_MAG, 32'h80000000, 0, 0));
    directed.push_back(vector_item(OP_MAG, 32'h0, 0, 0));
    directed.push_back(vector_item(OP_MAG, 32'h00030000, 0, 0));
    directed.push_back(vector_item(4'd10, 32'h7fffffff, 32'h1, 32'h1));
    directed.push_back(vector_item(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff));

    foreach (directed[i]) begin
      transfer(directed[i]);
      maybe_idle(1'b1);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      transfer(random_item());
      maybe_idle(n < RANDOM_ITEMS - CALM_TAIL);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("vec4_arithmetic_unit regression: pass");
    end else begin
      $display("vec4_arithmetic_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/v4au_pkg.sv
rtl/v4au_div.sv
rtl/v4au_sqrt.sv
rtl/vec4_arithmetic_unit.sv
bench/v4au_checker.sv
bench/testbench.sv
